>>> design/rgq_pkg.sv
// package: frame geometry, field widths, luma weights and shared types
`default_nettype none

package rgq_pkg;

    localparam int unsigned SRC_WIDTH  = 160;
    localparam int unsigned SRC_HEIGHT = 120;
    localparam int unsigned OUT_WIDTH  = 96;
    localparam int unsigned OUT_HEIGHT = 96;

    localparam int unsigned COL_STEP_INT = SRC_WIDTH / OUT_WIDTH;
    localparam int unsigned COL_STEP_REM = SRC_WIDTH % OUT_WIDTH;
    localparam int unsigned ROW_STEP_INT = SRC_HEIGHT / OUT_HEIGHT;
    localparam int unsigned ROW_STEP_REM = SRC_HEIGHT % OUT_HEIGHT;

    localparam int SCW = $clog2(SRC_WIDTH);
    localparam int SRW = $clog2(SRC_HEIGHT);
    localparam int NCW = $clog2(OUT_WIDTH + 1);
    localparam int NRW = $clog2(OUT_HEIGHT + 1);
    localparam int CTW = $clog2(SRC_WIDTH + 1);
    localparam int RTW = $clog2(SRC_HEIGHT + 1);
    localparam int CFW = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
    localparam int RFW = (OUT_HEIGHT > 1) ? $clog2(OUT_HEIGHT) : 1;

    localparam int PIXEL_W = 16;
    localparam int VALUE_W = 8;
    localparam int COORD_W = 7;

    localparam logic [VALUE_W-1:0] ZP_RESET = 8'h80;

    localparam logic [15:0] LUMA_R = 16'd77;
    localparam logic [15:0] LUMA_G = 16'd150;
    localparam logic [15:0] LUMA_B = 16'd29;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } rgq_hit_t;

endpackage

`default_nettype wire

>>> design/rgq_ifs.sv
// interfaces: pixel input, gray result and zero point write channels
`default_nettype none

interface rgq_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;
    logic        first_of_frame;

    modport source (output valid, output pixel, output first_of_frame, input ready);
    modport sink   (input valid, input pixel, input first_of_frame, output ready);
endinterface

interface rgq_res_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] value;
    logic [6:0]        out_col;
    logic [6:0]        out_row;
    logic              last;

    modport source (output valid, output value, output out_col, output out_row,
                    output last, input ready);
    modport sink   (input valid, input value, input out_col, input out_row,
                    input last, output ready);
endinterface

interface rgq_cfg_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] zp;

    modport source (output valid, output zp, input ready);
    modport sink   (input valid, input zp, output ready);
endinterface

`default_nettype wire

>>> design/rgq_scan.sv
// source position counters and exact nearest-neighbor step accumulators
`default_nettype none

module rgq_scan
    import rgq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire logic     first_of_frame,
    output rgq_hit_t      hit
);

    logic [SCW-1:0] src_col_reg,    src_col_next;
    logic [SRW-1:0] src_row_reg,    src_row_next;
    logic [NCW-1:0] next_col_reg,   next_col_next;
    logic [CTW-1:0] col_target_reg, col_target_next;
    logic [CFW-1:0] col_frac_reg,   col_frac_next;
    logic [NRW-1:0] next_row_reg,   next_row_next;
    logic [RTW-1:0] row_target_reg, row_target_next;
    logic [RFW-1:0] row_frac_reg,   row_frac_next;

    // state as seen after a resync
    logic [SCW-1:0] src_col;
    logic [SRW-1:0] src_row;
    logic [NCW-1:0] next_col;
    logic [CTW-1:0] col_target;
    logic [CFW-1:0] col_frac;
    logic [NRW-1:0] next_row;
    logic [RTW-1:0] row_target;
    logic [RFW-1:0] row_frac;

    logic           row_hit;
    logic           col_hit;
    logic [CFW:0]   col_frac_sum;
    logic [RFW:0]   row_frac_sum;

    always_comb
    begin
        src_col    = first_of_frame ? '0 : src_col_reg;
        src_row    = first_of_frame ? '0 : src_row_reg;
        next_col   = first_of_frame ? '0 : next_col_reg;
        col_target = first_of_frame ? '0 : col_target_reg;
        col_frac   = first_of_frame ? '0 : col_frac_reg;
        next_row   = first_of_frame ? '0 : next_row_reg;
        row_target = first_of_frame ? '0 : row_target_reg;
        row_frac   = first_of_frame ? '0 : row_frac_reg;

        row_hit = (next_row < NRW'(OUT_HEIGHT)) && (RTW'(src_row) == row_target);
        col_hit = (next_col < NCW'(OUT_WIDTH)) && (CTW'(src_col) == col_target);

        hit.hit  = row_hit && col_hit;
        hit.col  = COORD_W'(next_col);
        hit.row  = COORD_W'(next_row);
        hit.last = (next_col == NCW'(OUT_WIDTH - 1)) && (next_row == NRW'(OUT_HEIGHT - 1));

        col_frac_sum = {1'b0, col_frac} + (CFW + 1)'(COL_STEP_REM);
        row_frac_sum = {1'b0, row_frac} + (RFW + 1)'(ROW_STEP_REM);

        src_col_next    = src_col;
        src_row_next    = src_row;
        next_col_next   = next_col;
        col_target_next = col_target;
        col_frac_next   = col_frac;
        next_row_next   = next_row;
        row_target_next = row_target;
        row_frac_next   = row_frac;

        if (hit.hit)
        begin
            next_col_next = next_col + NCW'(1);
            if (col_frac_sum >= (CFW + 1)'(OUT_WIDTH))
            begin
                col_frac_next   = CFW'(col_frac_sum - (CFW + 1)'(OUT_WIDTH));
                col_target_next = col_target + CTW'(COL_STEP_INT) + CTW'(1);
            end
            else
            begin
                col_frac_next   = CFW'(col_frac_sum);
                col_target_next = col_target + CTW'(COL_STEP_INT);
            end
        end

        if (src_col >= SCW'(SRC_WIDTH - 1))
        begin
            src_col_next    = '0;
            next_col_next   = '0;
            col_target_next = '0;
            col_frac_next   = '0;
            if (src_row >= SRW'(SRC_HEIGHT - 1))
            begin
                src_row_next    = '0;
                next_row_next   = '0;
                row_target_next = '0;
                row_frac_next   = '0;
            end
            else
            begin
                src_row_next = src_row + SRW'(1);
                if (row_hit)
                begin
                    next_row_next = next_row + NRW'(1);
                    if (row_frac_sum >= (RFW + 1)'(OUT_HEIGHT))
                    begin
                        row_frac_next   = RFW'(row_frac_sum - (RFW + 1)'(OUT_HEIGHT));
                        row_target_next = row_target + RTW'(ROW_STEP_INT) + RTW'(1);
                    end
                    else
                    begin
                        row_frac_next   = RFW'(row_frac_sum);
                        row_target_next = row_target + RTW'(ROW_STEP_INT);
                    end
                end
            end
        end
        else
        begin
            src_col_next = src_col + SCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            next_col_reg   <= '0;
            col_target_reg <= '0;
            col_frac_reg   <= '0;
            next_row_reg   <= '0;
            row_target_reg <= '0;
            row_frac_reg   <= '0;
        end
        else if (step)
        begin
            src_col_reg    <= src_col_next;
            src_row_reg    <= src_row_next;
            next_col_reg   <= next_col_next;
            col_target_reg <= col_target_next;
            col_frac_reg   <= col_frac_next;
            next_row_reg   <= next_row_next;
            row_target_reg <= row_target_next;
            row_frac_reg   <= row_frac_next;
        end
    end

`ifndef SYNTH
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        src_col_reg <= SCW'(SRC_WIDTH - 1))
        else $error("source column beyond row length");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        src_row_reg <= SRW'(SRC_HEIGHT - 1))
        else $error("source row beyond frame height");

    a_frac_below_out: assert property (@(posedge clk) disable iff (!rst_n)
        (CFW + 1)'(col_frac_reg) < (CFW + 1)'(OUT_WIDTH))
        else $error("column remainder not reduced");
`endif

endmodule

`default_nettype wire

>>> design/rgb565_gray_downscale_quant.sv
// top level: rgb565 to quantized gray with nearest-neighbor downscale
//
// pix carries rgb565 source pixels in raster order, one transaction per
// pixel; first_of_frame marks source pixel (0,0) and resyncs all counters.
// a frame also wraps on its own after the last source pixel.
// res carries one transaction per kept pixel: gray minus zero point as
// signed 8 bits, output column and row, and last on the final output pixel.
// cfg writes the zero point (reset -128); it is always ready and should
// only be written while no pixel is in flight.
// a kept pixel shows on res in the cycle after its pix transaction.
// throughput: one pixel per cycle, set by the single result register;
// pix.ready drops only while a result waits and res.ready is low.
// reset clears the counters and the result valid and sets the zero point
// to -128; a stalled receiver holds the result and stalls pix behind it.
`default_nettype none

module rgb565_gray_downscale_quant
    import rgq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rgq_pix_if.sink   pix,
    rgq_res_if.source res,
    rgq_cfg_if.sink   cfg
);

    logic [VALUE_W-1:0] zp_reg;
    logic               res_valid_reg, res_valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic               last_reg;

    logic               pix_fire;
    logic               res_fire;
    rgq_hit_t           hit;
    logic [15:0]        r8, g8, b8;
    logic [15:0]        luma_sum;
    logic [VALUE_W-1:0] gray;

    assign cfg.ready = 1'b1;
    assign pix.ready = !res_valid_reg || res.ready;
    assign pix_fire  = pix.valid && pix.ready;
    assign res_fire  = res_valid_reg && res.ready;

    rgq_scan u_scan
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (pix_fire),
        .first_of_frame (pix.first_of_frame),
        .hit            (hit)
    );

    always_comb
    begin
        r8       = {8'd0, pix.pixel[15:11], 3'd0};
        g8       = {8'd0, pix.pixel[10:5], 2'd0};
        b8       = {8'd0, pix.pixel[4:0], 3'd0};
        luma_sum = LUMA_R * r8 + LUMA_G * g8 + LUMA_B * b8;
        gray     = luma_sum[15:8];

        res_valid_next = res_valid_reg;
        if (pix_fire)
        begin
            res_valid_next = hit.hit;
        end
        else if (res_fire)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zp_reg <= ZP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            zp_reg <= cfg.zp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire && hit.hit)
        begin
            value_reg   <= gray - zp_reg;
            out_col_reg <= hit.col;
            out_row_reg <= hit.row;
            last_reg    <= hit.last;
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.value   = value_reg;
    assign res.out_col = out_col_reg;
    assign res.out_row = out_row_reg;
    assign res.last    = last_reg;

`ifndef SYNTH
    a_hit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_fire && hit.hit) |=> res_valid_reg)
        else $error("kept pixel produced no result");

    a_miss_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_fire && !hit.hit) |=> !res_valid_reg)
        else $error("dropped pixel produced a result");

    a_resync_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_fire && pix.first_of_frame) |=>
            (res_valid_reg && out_col_reg == '0 && out_row_reg == '0))
        else $error("first pixel of frame not at output origin");

    a_empty_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> pix.ready)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
